>>> hw/rtl/cdt_pkg.sv
package cdt_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned IDX_W  = 8;

  typedef struct packed {
    logic [WORD_W-1:0] key_word;
    logic              last_word;
  } cdt_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic             is_new;
    logic             table_full;
  } cdt_out_t;

  // key buffer control
  typedef struct packed {
    logic wr;   // take one incoming word
    logic rd;   // read one word of the pending key
    logic clr;  // drop the pending key
  } cdt_kb_ctl_t;

  // key store control
  typedef struct packed {
    logic rd;
    logic wr;
  } cdt_st_ctl_t;

endpackage

>>> hw/rtl/cdt_key_buf.sv
module cdt_key_buf import cdt_pkg::*; #(
  parameter int unsigned KEY_WORDS = 24,
  parameter int unsigned WW        = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdt_kb_ctl_t       ctl_i,
  input  logic [WORD_W-1:0] wr_data_i,
  input  logic [WW-1:0]     rd_addr_i,
  output logic [WORD_W-1:0] rd_data_o
);

  localparam int unsigned PW = $clog2(KEY_WORDS + 1);

  logic [WORD_W-1:0]    mem [KEY_WORDS];
  logic [WORD_W-1:0]    rd_q;
  logic                 rd_vld_q;
  logic [KEY_WORDS-1:0] vld_q, vld_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic                 room;

  // words past the key length are dropped, the position saturates
  assign room = (pos_q < PW'(KEY_WORDS));

  always_comb begin
    vld_d = vld_q;
    pos_d = pos_q;
    if (ctl_i.clr) begin
      vld_d = '0;
      pos_d = '0;
    end else if (ctl_i.wr && room) begin
      vld_d[pos_q[WW-1:0]] = 1'b1;
      pos_d = pos_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      pos_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      pos_q <= pos_d;
      if (ctl_i.rd) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr && room && !ctl_i.clr) begin
      mem[pos_q[WW-1:0]] <= wr_data_i;
    end
    if (ctl_i.rd) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // slices never sent read as zero
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

>>> hw/rtl/cdt_key_store.sv
module cdt_key_store import cdt_pkg::*; #(
  parameter int unsigned DEPTH = 6144,
  parameter int unsigned AW    = 13
) (
  input  logic              clk_i,
  input  cdt_st_ctl_t       ctl_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> hw/rtl/coefficient_dedup_table.sv
// Key dedup table. A key arrives as KEY_WORDS words of 64 bits, one per accepted
// item, the final one marked by last_word. On the final word the block scans
// the stored keys one 64-bit word per cycle out of a single-port-read memory,
// stopping at the first exact bit match. On a miss the key is copied into the
// table as a new entry, unless the table is full, which is reported through
// table_full; an empty table skips the scan. busy_o is high from the final
// word's accept until the result appears. Exactly one result comes per key,
// on res_valid_o for one cycle; it cannot be held off, so the receiver must
// take it when it appears. No clearing pass is needed after reset.
module coefficient_dedup_table import cdt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_WORDS   = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  cdt_in_t  in_i,
  output logic     res_valid_o,
  output cdt_out_t res_o
);

  localparam int unsigned EW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WW  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int unsigned SD  = TABLE_DEPTH * KEY_WORDS;
  localparam int unsigned SAW = $clog2(SD);
  localparam int unsigned XW  = (EW > IDX_W) ? EW : IDX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_COPY = 2'd2;

  logic [1:0]     state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [SAW-1:0] base_q, base_d;     // count * KEY_WORDS
  logic [EW-1:0]  ent_q, ent_d;
  logic [WW-1:0]  wrd_q, wrd_d;
  logic [SAW-1:0] saddr_q, saddr_d;   // scan read address / copy write address
  logic           done_q, done_d;     // all reads issued
  logic           cv_q, cv_d;         // read data valid next cycle
  logic           clast_q, clast_d;   // that data is an entry's last word
  logic [EW-1:0]  cent_q, cent_d;
  logic           mis_q, mis_d;
  logic           rv_q, rv_d;
  cdt_out_t       res_q, res_d;

  cdt_kb_ctl_t       kb_ctl;
  cdt_st_ctl_t       st_ctl;
  logic [WORD_W-1:0] kb_rdata, st_rdata;
  logic              accept, wlast, elast, cur_mis;
  logic [XW-1:0]     idx_ext;

  assign accept  = start_i && (state_q == S_IDLE);
  assign wlast   = (wrd_q == WW'(KEY_WORDS - 1));
  assign elast   = (CW'(ent_q) == count_q - CW'(1));
  assign cur_mis = (st_rdata != kb_rdata);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    base_d  = base_q;
    ent_d   = ent_q;
    wrd_d   = wrd_q;
    saddr_d = saddr_q;
    done_d  = done_q;
    cv_d    = 1'b0;
    clast_d = clast_q;
    cent_d  = cent_q;
    mis_d   = mis_q;
    rv_d    = 1'b0;
    res_d   = res_q;
    kb_ctl  = '0;
    st_ctl  = '0;
    idx_ext = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kb_ctl.wr = 1'b1;
          if (in_i.last_word) begin
            ent_d  = '0;
            wrd_d  = '0;
            done_d = 1'b0;
            mis_d  = 1'b0;
            if (count_q == '0) begin
              saddr_d = base_q;
              state_d = S_COPY;
            end else begin
              saddr_d = '0;
              state_d = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (!done_q) begin
          kb_ctl.rd = 1'b1;
          st_ctl.rd = 1'b1;
          cv_d      = 1'b1;
          clast_d   = wlast;
          cent_d    = ent_q;
          saddr_d   = saddr_q + SAW'(1);
          if (wlast) begin
            wrd_d = '0;
            ent_d = ent_q + EW'(1);
            if (elast) begin
              done_d = 1'b1;
            end
          end else begin
            wrd_d = wrd_q + WW'(1);
          end
        end
        if (cv_q) begin
          mis_d = mis_q | cur_mis;
          if (clast_q) begin
            mis_d = 1'b0;
            if (!(mis_q || cur_mis)) begin
              // hit: drop in-flight reads
              idx_ext           = XW'(cent_q);
              res_d.entry_index = idx_ext[IDX_W-1:0];
              res_d.is_new      = 1'b0;
              res_d.table_full  = 1'b0;
              rv_d              = 1'b1;
              kb_ctl.clr        = 1'b1;
              cv_d              = 1'b0;
              state_d           = S_IDLE;
            end else if (CW'(cent_q) == count_q - CW'(1)) begin
              if (count_q == CW'(TABLE_DEPTH)) begin
                res_d.entry_index = '0;
                res_d.is_new      = 1'b0;
                res_d.table_full  = 1'b1;
                rv_d              = 1'b1;
                kb_ctl.clr        = 1'b1;
                state_d           = S_IDLE;
              end else begin
                wrd_d   = '0;
                done_d  = 1'b0;
                saddr_d = base_q;
                state_d = S_COPY;
              end
            end
          end
        end
      end

      S_COPY: begin
        if (!done_q) begin
          kb_ctl.rd = 1'b1;
          cv_d      = 1'b1;
          clast_d   = wlast;
          if (wlast) begin
            done_d = 1'b1;
          end else begin
            wrd_d = wrd_q + WW'(1);
          end
        end
        if (cv_q) begin
          st_ctl.wr = 1'b1;
          saddr_d   = saddr_q + SAW'(1);
          if (clast_q) begin
            idx_ext           = XW'(count_q[EW-1:0]);
            res_d.entry_index = idx_ext[IDX_W-1:0];
            res_d.is_new      = 1'b1;
            res_d.table_full  = 1'b0;
            rv_d              = 1'b1;
            kb_ctl.clr        = 1'b1;
            count_d           = count_q + CW'(1);
            base_d            = base_q + SAW'(KEY_WORDS);
            state_d           = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      base_q  <= '0;
      ent_q   <= '0;
      wrd_q   <= '0;
      saddr_q <= '0;
      done_q  <= 1'b0;
      cv_q    <= 1'b0;
      clast_q <= 1'b0;
      mis_q   <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      base_q  <= base_d;
      ent_q   <= ent_d;
      wrd_q   <= wrd_d;
      saddr_q <= saddr_d;
      done_q  <= done_d;
      cv_q    <= cv_d;
      clast_q <= clast_d;
      mis_q   <= mis_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cent_q <= cent_d;
    res_q  <= res_d;
  end

  cdt_key_buf #(
    .KEY_WORDS (KEY_WORDS),
    .WW        (WW)
  ) u_key_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (kb_ctl),
    .wr_data_i (in_i.key_word),
    .rd_addr_i (wrd_q),
    .rd_data_o (kb_rdata)
  );

  cdt_key_store #(
    .DEPTH (SD),
    .AW    (SAW)
  ) u_key_store (
    .clk_i     (clk_i),
    .ctl_i     (st_ctl),
    .rd_addr_i (saddr_q),
    .wr_addr_i (saddr_q),
    .wr_data_i (kb_rdata),
    .rd_data_o (st_rdata)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

endmodule
